@@ design/chp_pkg.sv @@
package chp_pkg;

  // build-time sizing
  localparam int NUM_CORES      = 4;
  localparam int LOAD_FRAC_BITS = 11;

  // field widths
  localparam int AVG_W   = 20;
  localparam int RQ_W    = 16;
  localparam int CPU_W   = 3;
  localparam int TIME_W  = 32;
  localparam int DELAY_W = 10;
  localparam int PERS_W  = 4;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;

  // interval and hold constants
  localparam logic [DELAY_W-1:0] DEF_INTERVAL  = 10'd1000;
  localparam logic [DELAY_W-1:0] BUSY_INTERVAL = 10'd500;
  localparam logic [DELAY_W-1:0] RESUME_DELAY  = 10'd10;
  localparam logic [PERS_W-1:0]  BUSY_HOLD     = 4'd10;
  localparam logic [PERS_W-1:0]  DUAL_HOLD     = 4'd7;
  localparam logic [PERS_W-1:0]  DUAL_HOLD_LOW = 4'd3;

  // request kinds
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_TOUCH   = 2'd1,
    REQ_SUSPEND = 2'd2,
    REQ_RESUME  = 2'd3
  } req_t;

  // hotplug commands
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_OFFLINE = 2'd1,
    CMD_ONLINE  = 2'd2
  } cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_ECO_MODE    = 2'd1,
    CFG_TOUCH_BOOST = 2'd2
  } cfg_idx_t;

  // run-queue bounds per online count (row = online - 1)
  typedef logic [RQ_W-1:0] rq_row_t [0:2];
  localparam rq_row_t RQ_UP_BOUND   = '{16'd19, 16'd19, 16'd19};
  localparam rq_row_t RQ_IDLE_BOUND = '{16'd30, 16'd11, 16'd11};
  typedef logic [TIME_W-1:0] tm_row_t [0:2];
  localparam tm_row_t TIME_BOUND    = '{32'd140, 32'd140, 32'd140};

  // full-mode load thresholds, whole threads
  typedef logic [4:0] thr_row_t [1:3];
  localparam thr_row_t FULL_THR = '{5'd5, 5'd7, 5'd9};
  localparam logic [4:0] ECO_THR  = 5'd3;
  localparam logic [4:0] ECO_HYST = 5'd4;
  localparam logic [4:0] FULL_HYST = 5'd8;
  localparam int ECO_SHIFT  = 1;
  localparam int FULL_SHIFT = 3;

endpackage

@@ design/core_hotplug_policy.sv @@
// channel  direction  handshake                 payload
// in_      input      in_tvalid / in_tready     tuser req_type, tdata load sample
// out_     output     out_tvalid / out_tready   tdata command and status
// cfg_     input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one request per cycle sustained while out_tready is high; out_tvalid rises once the accepted
// request has passed the input register, then policy logic into the result register and state
// rst_n is synchronous, active low; it resets control, configuration, policy state and valid flags
// a stalled result holds the pipeline; the input register still takes a request while it is
// empty or the result register is free or being drained
// cfg_ready is always high
module core_hotplug_policy (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] req_type
  input  logic [1:0]                          in_tuser,
  // [19:0] avg_running, [35:20] queue_depth, [38:36] online_cpus, [70:39] now_ms, [71] zero
  input  logic [chp_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] cmd, [4:2] target_cores, [14:5] next_delay_ms, [17:15] run_stat,
  // [18] stat_error, [23:19] zero
  output logic [chp_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic                                cfg_data
);

  localparam int AW = chp_pkg::AVG_W;
  localparam int RW = chp_pkg::RQ_W;
  localparam int CW = chp_pkg::CPU_W;
  localparam int TW = chp_pkg::TIME_W;
  localparam int DW = chp_pkg::DELAY_W;
  localparam int PW = chp_pkg::PERS_W;

  // input register
  logic          in_v_r;
  logic [1:0]    req_r;
  logic [AW-1:0] avg_r;
  logic [RW-1:0] rq_r;
  logic [CW-1:0] online_r;
  logic [TW-1:0] now_r;

  // result register
  logic          out_v_r;
  logic [1:0]    cmd_r;
  logic [2:0]    target_r;
  logic [DW-1:0] delay_r;
  logic [2:0]    stat_r;
  logic          err_r;

  // configuration
  logic enable_r, eco_r, touch_r;

  // policy state
  logic [2:0]    last_target_r, last_target_nxt;
  logic [PW-1:0] down_r, down_nxt;
  logic [PW-1:0] busy_r, busy_nxt;
  logic [DW-1:0] interval_r, interval_nxt;
  logic          asleep_r, asleep_nxt;
  logic          first_r, first_nxt;
  logic [TW-1:0] last_vote_r, last_vote_nxt;
  logic [TW-1:0] accum_r, accum_nxt;

  // result values
  logic [1:0]    cmd_nxt;
  logic [2:0]    target_nxt;
  logic [DW-1:0] delay_nxt;
  logic [2:0]    stat_nxt;
  logic          err_nxt;

  logic advance;
  logic fire;

  assign advance   = !out_v_r || out_tready;
  assign fire      = in_v_r && advance;
  assign in_tready = !in_v_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, err_r, stat_r, delay_r, target_r, cmd_r};

  // load-based core target with hysteresis on the previous target
  function automatic logic [2:0] load_target(input logic [AW-1:0] avg,
                                             input logic eco,
                                             input logic [2:0] last);
    logic [2:0]    n;
    logic [4:0]    thr;
    logic [AW+4:0] lim;
    n = eco ? 3'd2 : 3'd4;
    for (int i = 3; i >= 1; i--) begin
      if (!eco || i == 1) begin
        thr = eco ? chp_pkg::ECO_THR : chp_pkg::FULL_THR[i];
        if (last <= 3'(i))
          thr = thr + (eco ? chp_pkg::ECO_HYST : chp_pkg::FULL_HYST);
        if (eco)
          lim = (AW+5)'(thr) << (chp_pkg::LOAD_FRAC_BITS - chp_pkg::ECO_SHIFT);
        else
          lim = (AW+5)'(thr) << (chp_pkg::LOAD_FRAC_BITS - chp_pkg::FULL_SHIFT);
        if ((AW+5)'(avg) <= lim)
          n = 3'(i);
      end
    end
    return n;
  endfunction

  // policy logic for the request in the input register
  always_comb begin
    logic [2:0]    count;
    logic          vote;
    logic [1:0]    row;
    logic [TW-1:0] d;
    logic [TW:0]   sum;
    logic [TW-1:0] acc;

    last_target_nxt = last_target_r;
    down_nxt        = down_r;
    busy_nxt        = busy_r;
    interval_nxt    = interval_r;
    asleep_nxt      = asleep_r;
    first_nxt       = first_r;
    last_vote_nxt   = last_vote_r;
    accum_nxt       = accum_r;

    cmd_nxt    = chp_pkg::CMD_NONE;
    target_nxt = 3'd1;
    delay_nxt  = '0;
    stat_nxt   = '0;
    err_nxt    = 1'b0;

    count = '0;
    vote  = 1'b0;
    row   = 2'(online_r - 3'd1);
    d     = now_r - last_vote_r;
    sum   = {1'b0, accum_r} + {1'b0, d};
    acc   = accum_r;

    case (req_r)
      chp_pkg::REQ_TICK: begin
        if (enable_r) begin
          count           = load_target(avg_r, eco_r, last_target_r);
          stat_nxt        = count;
          last_target_nxt = count;

          // run-queue vote in full mode
          if (!eco_r && online_r >= 3'd1 && online_r < 3'd4) begin
            if (first_r)
              first_nxt = 1'b0;
            else
              acc = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
            if (rq_r >= chp_pkg::RQ_UP_BOUND[row]) begin
              vote = (acc >= chp_pkg::TIME_BOUND[row]);
            end else if (rq_r > chp_pkg::RQ_IDLE_BOUND[row]) begin
              acc = '0;
            end
            accum_nxt     = acc;
            last_vote_nxt = now_r;
            if (vote) begin
              if (online_r == 3'd2)
                count = 3'd3;
              else if (online_r == 3'd3)
                count = 3'd4;
            end
          end

          // busy persistence sets the sampling interval
          if (count > 3'd2) begin
            if (busy_r == '0) begin
              interval_nxt = chp_pkg::BUSY_INTERVAL;
              busy_nxt     = chp_pkg::BUSY_HOLD;
            end
          end else if (busy_r != '0) begin
            busy_nxt = busy_r - 1'b1;
          end else begin
            interval_nxt = chp_pkg::DEF_INTERVAL;
          end

          // hotplug decision while awake
          if (!asleep_r) begin
            if (count == 3'd1) begin
              if (down_r != '0)
                down_nxt = down_r - 1'b1;
              if (down_r <= PW'(1)) begin
                cmd_nxt    = chp_pkg::CMD_OFFLINE;
                target_nxt = 3'd1;
              end
            end else if (count == 3'd2) begin
              down_nxt   = vote ? chp_pkg::DUAL_HOLD : chp_pkg::DUAL_HOLD_LOW;
              cmd_nxt    = (online_r < 3'd2) ? chp_pkg::CMD_ONLINE : chp_pkg::CMD_OFFLINE;
              target_nxt = 3'd2;
            end else begin
              err_nxt = 1'b1;
            end
          end
        end
        delay_nxt = interval_nxt;
      end
      chp_pkg::REQ_TOUCH: begin
        if (touch_r && online_r < 3'd2) begin
          cmd_nxt    = chp_pkg::CMD_ONLINE;
          target_nxt = 3'd2;
        end
      end
      chp_pkg::REQ_SUSPEND: begin
        asleep_nxt = 1'b1;
        cmd_nxt    = chp_pkg::CMD_OFFLINE;
        target_nxt = 3'd1;
      end
      chp_pkg::REQ_RESUME: begin
        down_nxt   = chp_pkg::BUSY_HOLD;
        asleep_nxt = 1'b0;
        cmd_nxt    = chp_pkg::CMD_ONLINE;
        target_nxt = eco_r ? 3'd1 : 3'(chp_pkg::NUM_CORES);
        delay_nxt  = chp_pkg::RESUME_DELAY;
      end
      default: begin
        cmd_nxt = chp_pkg::CMD_NONE;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      req_r    <= in_tuser;
      avg_r    <= in_tdata[19:0];
      rq_r     <= in_tdata[35:20];
      online_r <= in_tdata[38:36];
      now_r    <= in_tdata[70:39];
    end
  end

  // result register and policy state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r       <= 1'b0;
      last_target_r <= '0;
      down_r        <= '0;
      busy_r        <= '0;
      interval_r    <= chp_pkg::DEF_INTERVAL;
      asleep_r      <= 1'b0;
      first_r       <= 1'b1;
      last_vote_r   <= '0;
      accum_r       <= '0;
    end else if (fire) begin
      out_v_r       <= 1'b1;
      last_target_r <= last_target_nxt;
      down_r        <= down_nxt;
      busy_r        <= busy_nxt;
      interval_r    <= interval_nxt;
      asleep_r      <= asleep_nxt;
      first_r       <= first_nxt;
      last_vote_r   <= last_vote_nxt;
      accum_r       <= accum_nxt;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (fire) begin
      cmd_r    <= cmd_nxt;
      target_r <= target_nxt;
      delay_r  <= delay_nxt;
      stat_r   <= stat_nxt;
      err_r    <= err_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      eco_r    <= 1'b0;
      touch_r  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        chp_pkg::CFG_ENABLE:      enable_r <= cfg_data;
        chp_pkg::CFG_ECO_MODE:    eco_r    <= cfg_data;
        chp_pkg::CFG_TOUCH_BOOST: touch_r  <= cfg_data;
        default: begin
          enable_r <= enable_r;
        end
      endcase
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import chp_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SHOWN_MAX     = 10;
  localparam int DRAIN_CYCLES  = 4;

  // run-queue vote bounds and load thresholds
  localparam int RQ_UP_LVL     = 19;
  localparam int RQ_IDLE_ONE   = 30;
  localparam int RQ_IDLE_MULTI = 11;
  localparam int VOTE_HOLD_MS  = 140;
  localparam int ECO_LVL       = 3;

  typedef struct packed {
    req_t        kind;
    logic [19:0] avg;
    logic [15:0] rq;
    logic [2:0]  online;
    logic [31:0] now;
  } request_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  cores;
    logic [9:0]  delay;
    logic [2:0]  load;
    logic        err;
  } decision_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [1:0]             in_tuser = '0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = '0;
  logic                   cfg_data = 1'b0;

  core_hotplug_policy dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  request_t    req_q[$];
  decision_t   decision_q[$];
  bit          in_fire = 1'b0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          fail_cnt = 0;
  int          result_cnt = 0;
  int          cycle_cnt = 0;
  logic [31:0] t_now = '0;

  // shadow of the policy registers and state
  bit          pol_enable = 1'b0;
  bit          pol_eco = 1'b0;
  bit          pol_touch = 1'b1;
  int          lvl_prev = 0;
  int          down_hold = 0;
  int          busy_hold = 0;
  logic [9:0]  interval_ms = DEF_INTERVAL;
  bit          sleeping = 1'b0;
  bit          vote_fresh = 1'b1;
  logic [31:0] vote_stamp = '0;
  logic [31:0] wait_accum = '0;

  // load level with hysteresis against the previous level
  function automatic int load_level(logic [19:0] avg);
    int n, top, hyst, shift, thr;
    bit hit;
    top = pol_eco ? 2 : 4;
    hyst = pol_eco ? 4 : 8;
    shift = pol_eco ? 1 : 3;
    n = 1;
    hit = 1'b0;
    while (n < top && !hit) begin
      thr = pol_eco ? ECO_LVL : (n == 1 ? 5 : (n == 2 ? 7 : 9));
      if (lvl_prev <= n)
        thr += hyst;
      if (int'(avg) <= (thr << (LOAD_FRAC_BITS - shift)))
        hit = 1'b1;
      else
        n++;
    end
    lvl_prev = n;
    return n;
  endfunction

  // run-queue up-vote over saturating accumulated time
  function automatic bit queue_vote(logic [15:0] rq, int online, logic [31:0] now);
    logic [32:0] sum;
    logic [31:0] gap;
    bit up;
    up = 1'b0;
    if (vote_fresh) begin
      vote_fresh = 1'b0;
    end else begin
      gap = now - vote_stamp;
      sum = {1'b0, wait_accum} + {1'b0, gap};
      wait_accum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
    if (rq >= RQ_UP_LVL)
      up = (wait_accum >= VOTE_HOLD_MS);
    else if (rq > (online == 1 ? RQ_IDLE_ONE : RQ_IDLE_MULTI))
      wait_accum = '0;
    vote_stamp = now;
    return up;
  endfunction

  function automatic decision_t policy_step(request_t r);
    decision_t d;
    int level, count;
    bit won;
    d.cmd = CMD_NONE;
    d.cores = 3'd1;
    d.delay = '0;
    d.load = '0;
    d.err = 1'b0;
    case (r.kind)
      REQ_TICK: begin
        if (pol_enable) begin
          won = 1'b0;
          level = load_level(r.avg);
          count = level;
          if (!pol_eco && r.online >= 1 && r.online < 4) begin
            won = queue_vote(r.rq, r.online, r.now);
            if (won && r.online == 2)
              count = 3;
            else if (won && r.online == 3)
              count = 4;
          end
          // busy hold keeps the short interval for a while
          if (count > 2) begin
            if (busy_hold == 0) begin
              interval_ms = BUSY_INTERVAL;
              busy_hold = BUSY_HOLD;
            end
          end else if (busy_hold > 0) begin
            busy_hold--;
          end else begin
            interval_ms = DEF_INTERVAL;
          end
          // hotplug action only while awake
          if (!sleeping) begin
            if (count == 1) begin
              if (down_hold > 0)
                down_hold--;
              if (down_hold == 0)
                d.cmd = CMD_OFFLINE;
            end else if (count == 2) begin
              down_hold = won ? DUAL_HOLD : DUAL_HOLD_LOW;
              d.cmd = (r.online < 2) ? CMD_ONLINE : CMD_OFFLINE;
              d.cores = 3'd2;
            end else begin
              d.err = 1'b1;
            end
          end
          d.load = 3'(level);
        end
        d.delay = interval_ms;
      end
      REQ_TOUCH: begin
        if (pol_touch && r.online < 2) begin
          d.cmd = CMD_ONLINE;
          d.cores = 3'd2;
        end
      end
      REQ_SUSPEND: begin
        sleeping = 1'b1;
        d.cmd = CMD_OFFLINE;
      end
      default: begin
        down_hold = BUSY_HOLD;
        sleeping = 1'b0;
        d.cmd = CMD_ONLINE;
        d.cores = pol_eco ? 3'd1 : 3'(NUM_CORES);
        d.delay = RESUME_DELAY;
      end
    endcase
    return d;
  endfunction

  // mostly well-paced ticks near the thresholds, some wild values
  function automatic request_t rand_request();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 80)
      r.kind = REQ_TICK;
    else if (pick < 88)
      r.kind = REQ_TOUCH;
    else if (pick < 92)
      r.kind = REQ_SUSPEND;
    else
      r.kind = REQ_RESUME;
    r.avg = ($urandom_range(99) < 80) ? 20'($urandom_range(8000)) : 20'($urandom);
    r.rq = ($urandom_range(99) < 70) ? 16'($urandom_range(40)) : 16'($urandom);
    r.online = ($urandom_range(99) < 85) ? 3'($urandom_range(4, 1)) : 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 85)
      t_now = t_now + $urandom_range(1100, 400);
    else if (pick < 95)
      t_now = t_now + $urandom_range(300);
    else
      t_now = $urandom;
    r.now = t_now;
    return r;
  endfunction

  task automatic push_req(req_t kind, logic [19:0] avg, logic [15:0] rq,
                          logic [2:0] online, logic [31:0] now);
    request_t r;
    r.kind = kind;
    r.avg = avg;
    r.rq = rq;
    r.online = online;
    r.now = now;
    req_q.push_back(r);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLE:   pol_enable = val;
      CFG_ECO_MODE: pol_eco = val;
      default:      pol_touch = val;
    endcase
  endtask

  task automatic set_mode(bit en, bit eco, bit tb);
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_ECO_MODE, eco);
    write_reg(CFG_TOUCH_BOOST, tb);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_all_results();
    while (req_q.size() != 0 || in_tvalid || decision_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    request_t nxt;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        nxt = req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.kind;
        in_tdata <= {1'b0, nxt.now, nxt.online, nxt.rq, nxt.avg};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // result checker and request predictor
  always @(posedge clk) begin
    decision_t want, got;
    request_t taken;
    in_fire = rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.cmd = cmd_t'(out_tdata[1:0]);
      got.cores = out_tdata[4:2];
      got.delay = out_tdata[14:5];
      got.load = out_tdata[17:15];
      got.err = out_tdata[18];
      if (decision_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= SHOWN_MAX)
          $display("result %0d with no request pending: cmd %0d cores %0d delay %0d",
                   result_cnt, got.cmd, got.cores, got.delay);
      end else begin
        want = decision_q.pop_front();
        if (got.cmd != want.cmd || got.cores != want.cores || got.delay != want.delay ||
            got.load != want.load || got.err != want.err) begin
          fail_cnt++;
          if (fail_cnt <= SHOWN_MAX)
            $display("result %0d: exp cmd %0d cores %0d delay %0d load %0d err %0d, got %0d %0d %0d %0d %0d",
                     result_cnt, want.cmd, want.cores, want.delay, want.load, want.err,
                     got.cmd, got.cores, got.delay, got.load, got.err);
        end
      end
      result_cnt++;
    end
    if (in_fire) begin
      taken.kind = req_t'(in_tuser);
      taken.avg = in_tdata[19:0];
      taken.rq = in_tdata[35:20];
      taken.online = in_tdata[38:36];
      taken.now = in_tdata[70:39];
      decision_q.push_back(policy_step(taken));
    end
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    bit en, eco, tb;
    int n;
    send_idle = 10;
    recv_idle = 57;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: policy off, touch boost on
    push_req(REQ_TICK, 20'hFFFFF, 16'hFFFF, 3'd2, 32'd0);
    push_req(REQ_TOUCH, 20'd0, 16'd0, 3'd1, 32'd0);
    wait_all_results();

    // full mode: first vote, vote wins, saturation, queue clear, odd counts, touch, suspend, resume
    set_mode(1'b1, 1'b0, 1'b1);
    push_req(REQ_TICK, 20'd0, 16'd0, 3'd1, 32'h0000_0000);
    push_req(REQ_TICK, 20'hFFFFF, 16'hFFFF, 3'd2, 32'h0000_0064);
    push_req(REQ_TICK, 20'hFFFFF, 16'hFFFF, 3'd2, 32'h0000_012C);
    push_req(REQ_TICK, 20'd0, 16'd20, 3'd3, 32'hF000_0000);
    push_req(REQ_TICK, 20'd0, 16'd5, 3'd3, 32'hE000_0000);
    push_req(REQ_TICK, 20'd0, 16'd19, 3'd3, 32'hE000_0001);
    push_req(REQ_TICK, 20'd3329, 16'd15, 3'd2, 32'hE000_0100);
    push_req(REQ_TICK, 20'd3328, 16'd40, 3'd1, 32'hE000_0300);
    push_req(REQ_TICK, 20'd3400, 16'd40, 3'd1, 32'hE000_0600);
    push_req(REQ_TICK, 20'd0, 16'd0, 3'd0, 32'hE000_0700);
    push_req(REQ_TICK, 20'd0, 16'd0, 3'd7, 32'hE000_0800);
    push_req(REQ_TICK, 20'd6000, 16'd0, 3'd4, 32'hE000_0900);
    push_req(REQ_TOUCH, 20'd0, 16'd0, 3'd0, 32'd0);
    push_req(REQ_TOUCH, 20'd0, 16'd0, 3'd3, 32'd0);
    push_req(REQ_SUSPEND, 20'd0, 16'd0, 3'd2, 32'd0);
    push_req(REQ_TICK, 20'hFFFFF, 16'd30, 3'd2, 32'hE000_0A00);
    push_req(REQ_RESUME, 20'd0, 16'd0, 3'd1, 32'd0);
    push_req(REQ_TICK, 20'd0, 16'd0, 3'd1, 32'hE000_0B00);
    wait_all_results();

    // eco mode, touch boost off
    set_mode(1'b1, 1'b1, 1'b0);
    push_req(REQ_TOUCH, 20'd0, 16'd0, 3'd1, 32'd0);
    push_req(REQ_RESUME, 20'd0, 16'd0, 3'd2, 32'd0);
    push_req(REQ_TICK, 20'd0, 16'd0, 3'd1, 32'd0);
    push_req(REQ_TICK, 20'd7168, 16'd0, 3'd2, 32'd500);
    push_req(REQ_TICK, 20'd7169, 16'd0, 3'd2, 32'd1000);
    push_req(REQ_TICK, 20'hFFFFF, 16'd40, 3'd3, 32'd1500);
    wait_all_results();

    // random phases over the register settings and idle patterns
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin en = 1'b1; eco = 1'b0; tb = 1'b1; end
        1: begin en = 1'b1; eco = 1'b1; tb = 1'b0; end
        2: begin en = 1'b0; eco = 1'b0; tb = 1'b1; end
        3: begin en = 1'b1; eco = 1'b0; tb = 1'b0; end
        4: begin en = 1'b1; eco = 1'b1; tb = 1'b1; end
        default: begin en = 1'b1; eco = 1'b0; tb = 1'b1; end
      endcase
      if (p == 2) begin
        send_idle = 57;
        recv_idle = 10;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      set_mode(en, eco, tb);
      n = (p == 2) ? 100 : 190;
      for (int i = 0; i < n; i++) begin
        // sender holds off mid-phase until the block is empty
        if (i == n / 2)
          wait_all_results();
        req_q.push_back(rand_request());
      end
      wait_all_results();
    end

    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && decision_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
